// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked within the same cycle.
`define TIG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tig assertion failed");

// Implication checked in the next cycle.
`define TIG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tig assertion failed");

`endif

// ===== rtl/core/tig_pkg.sv =====
package tig_pkg;

    localparam int IDX_W = 16;   // vertex index field width
    localparam int CNT_W = 6;    // point count field width
    localparam int ALPHA_W = 8;
    localparam int I_W = 5;      // step counter inside one phase
    localparam int LEFT_W = 6;   // triangles left in a request, at most 62

    localparam logic OP_FAN = 1'b0;
    localparam logic OP_ARC = 1'b1;

    typedef logic [2:0] phase_t;

    localparam phase_t PH_IDLE    = 3'd0;
    localparam phase_t PH_FAN     = 3'd1;
    localparam phase_t PH_PREFIX  = 3'd2;
    localparam phase_t PH_SUFFIX  = 3'd3;
    localparam phase_t PH_STRIP_A = 3'd4;
    localparam phase_t PH_STRIP_B = 3'd5;

    typedef struct packed {
        logic   idle;
        logic   load;
        logic   emit;
        logic   clr_cnt;
        logic   inc_cnt;
        phase_t phase;
    } tig_cmd_t;

    typedef struct packed {
        logic   req_ok;
        phase_t first_phase;
        logic   s_zero;
        logic   last;
        logic   prefix_end;
        logic   suffix_end;
        logic   slot_free;
    } tig_status_t;

endpackage

// ===== rtl/core/tig_req_if.sv =====
interface tig_req_if import tig_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [IDX_W-1:0]   base_vertex;
    logic [CNT_W-1:0]   outer_points;
    logic [CNT_W-1:0]   inner_points;
    logic [ALPHA_W-1:0] alpha;

    modport source (output valid, opcode, base_vertex, outer_points, inner_points, alpha,
                    input ready);
    modport sink (input valid, opcode, base_vertex, outer_points, inner_points, alpha,
                  output ready);
endinterface

// ===== rtl/core/tig_tri_if.sv =====
interface tig_tri_if import tig_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic             last;

    modport source (output valid, index_a, index_b, index_c, last, input ready);
    modport sink (input valid, index_a, index_b, index_c, last, output ready);
endinterface

// ===== rtl/core/tig_ctrl.sv =====
module tig_ctrl import tig_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  tig_status_t sts,
    output tig_cmd_t    cmd
);

    localparam phase_t ST_IDLE    = PH_IDLE;
    localparam phase_t ST_FAN     = PH_FAN;
    localparam phase_t ST_PREFIX  = PH_PREFIX;
    localparam phase_t ST_SUFFIX  = PH_SUFFIX;
    localparam phase_t ST_STRIP_A = PH_STRIP_A;
    localparam phase_t ST_STRIP_B = PH_STRIP_B;

    phase_t state_reg;
    phase_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.idle    = (state_reg == ST_IDLE);
        cmd.phase   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.clr_cnt = 1'b1;
                    if (sts.req_ok)
                    begin
                        state_next = sts.first_phase;
                    end
                end
            end
            ST_FAN, ST_PREFIX, ST_SUFFIX, ST_STRIP_A, ST_STRIP_B:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        unique case (state_reg)
                            ST_PREFIX:
                            begin
                                if (sts.prefix_end)
                                begin
                                    cmd.clr_cnt = 1'b1;
                                    state_next  = sts.s_zero ? ST_STRIP_A : ST_SUFFIX;
                                end
                                else
                                begin
                                    cmd.inc_cnt = 1'b1;
                                end
                            end
                            ST_SUFFIX:
                            begin
                                if (sts.suffix_end)
                                begin
                                    cmd.clr_cnt = 1'b1;
                                    state_next  = ST_STRIP_A;
                                end
                                else
                                begin
                                    cmd.inc_cnt = 1'b1;
                                end
                            end
                            ST_STRIP_A:
                            begin
                                state_next = ST_STRIP_B;
                            end
                            ST_STRIP_B:
                            begin
                                cmd.inc_cnt = 1'b1;
                                state_next  = ST_STRIP_A;
                            end
                            default:
                            begin
                                cmd.inc_cnt = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tig_datapath.sv =====
module tig_datapath import tig_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tig_req_if.sink     req,
    tig_tri_if.source   triangle,
    input  tig_cmd_t    cmd,
    output tig_status_t sts
);

    localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
        IDX_W'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    logic [IDX_W-1:0]  base_reg;
    logic [IDX_W-1:0]  ib_reg;      // first inner point
    logic [IDX_W-1:0]  il_reg;      // last inner point
    logic [IDX_W-1:0]  bp_reg;      // outer point where the strip starts
    logic [I_W-1:0]    p_reg;
    logic [I_W-1:0]    s_reg;
    logic [LEFT_W-1:0] left_reg;
    logic [I_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  c_reg;
    logic              last_reg;
    logic              valid_reg;

    logic [CNT_W-1:0]  in_diff;
    logic [I_W-1:0]    in_p;
    logic [I_W-1:0]    in_s;
    logic [CNT_W:0]    in_sum;
    logic              fan_ok;
    logic              arc_ok;
    logic [LEFT_W-1:0] in_total;

    logic [IDX_W-1:0]  ci;
    logic [IDX_W-1:0]  bci;
    logic [IDX_W-1:0]  ibci;
    logic [IDX_W-1:0]  bpci;
    logic [IDX_W-1:0]  at;
    logic [IDX_W-1:0]  tri_a;
    logic [IDX_W-1:0]  tri_b;
    logic [IDX_W-1:0]  tri_c;

    assign in_diff  = req.outer_points - req.inner_points;
    assign in_p     = I_W'(in_diff >> 1);
    assign in_s     = I_W'(in_diff - CNT_W'(in_p));
    assign in_sum   = {1'b0, req.outer_points} + {1'b0, req.inner_points};
    assign fan_ok   = (req.outer_points >= CNT_W'(3)) && (req.outer_points <= MAX_CNT);
    assign arc_ok   = (req.inner_points != '0) && (req.inner_points <= req.outer_points)
                    && (req.outer_points <= MAX_CNT) && (in_sum >= (CNT_W+1)'(3));
    assign in_total = (req.opcode == OP_ARC) ? LEFT_W'(in_sum - (CNT_W+1)'(2))
                                             : LEFT_W'(req.outer_points - CNT_W'(2));

    assign req.ready = cmd.idle;

    always_comb
    begin
        sts.req_ok = (req.alpha != '0) && ((req.opcode == OP_ARC) ? arc_ok : fan_ok);
        if (req.opcode == OP_FAN)
        begin
            sts.first_phase = PH_FAN;
        end
        else if (in_p != '0)
        begin
            sts.first_phase = PH_PREFIX;
        end
        else if (in_s != '0)
        begin
            sts.first_phase = PH_SUFFIX;
        end
        else
        begin
            sts.first_phase = PH_STRIP_A;
        end
        sts.s_zero     = (s_reg == '0);
        sts.last       = (left_reg == LEFT_W'(1));
        sts.prefix_end = ({1'b0, cnt_reg} + (I_W+1)'(1)) == {1'b0, p_reg};
        sts.suffix_end = ({1'b0, cnt_reg} + (I_W+1)'(1)) == {1'b0, s_reg};
        sts.slot_free  = !valid_reg || triangle.ready;
    end

    assign ci   = IDX_W'(cnt_reg);
    assign bci  = base_reg + ci;
    assign ibci = ib_reg + ci;
    assign bpci = bp_reg + ci;
    assign at   = ib_reg - ci - IDX_W'(2);

    always_comb
    begin
        unique case (cmd.phase)
            PH_PREFIX:
            begin
                tri_a = bci;
                tri_b = bci + IDX_W'(1);
                tri_c = ib_reg;
            end
            PH_SUFFIX:
            begin
                tri_a = at;
                tri_b = at + IDX_W'(1);
                tri_c = il_reg;
            end
            PH_STRIP_A:
            begin
                tri_a = bpci;
                tri_b = bpci + IDX_W'(1);
                tri_c = ibci + IDX_W'(1);
            end
            PH_STRIP_B:
            begin
                tri_a = bpci;
                tri_b = ibci + IDX_W'(1);
                tri_c = ibci;
            end
            default:
            begin
                tri_a = base_reg;
                tri_b = bci + IDX_W'(1);
                tri_c = bci + IDX_W'(2);
            end
        endcase
    end

    // request geometry, held for the whole run; output triangle word on each emit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= req.base_vertex;
            ib_reg   <= req.base_vertex + IDX_W'(req.outer_points);
            il_reg   <= req.base_vertex + IDX_W'(in_sum) - IDX_W'(1);
            bp_reg   <= req.base_vertex + IDX_W'(in_p);
            p_reg    <= in_p;
            s_reg    <= in_s;
        end
        if (cmd.emit)
        begin
            a_reg    <= tri_a & IDX_MASK;
            b_reg    <= tri_b & IDX_MASK;
            c_reg    <= tri_c & IDX_MASK;
            last_reg <= sts.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                left_reg <= in_total;
            end
            else if (cmd.emit)
            begin
                left_reg <= left_reg - LEFT_W'(1);
            end
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.inc_cnt)
            begin
                cnt_reg <= cnt_reg + I_W'(1);
            end
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (triangle.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign triangle.valid   = valid_reg;
    assign triangle.index_a = a_reg;
    assign triangle.index_b = b_reg;
    assign triangle.index_c = c_reg;
    assign triangle.last    = last_reg;

endmodule

// ===== rtl/core/triangle_index_generator.sv =====
// Triangle index generator.
// request channel: one word per draw request (opcode, base_vertex, outer_points,
//   inner_points, alpha). Fan mode gives outer_points-2 triangles, arc mode gives
//   outer_points+inner_points-2; a rejected request (alpha zero, bad counts) gives none.
// triangle channel: one word per triangle (index_a, index_b, index_c), last set on
//   the final triangle of the request. Indices wrap modulo 2^INDEX_BITS (2^IDX_W at most).
// The request is loaded into the sequencer, then the first triangle is registered in the
//   output register once it is free. A rejected request is only loaded. The rate is set
//   by the single index adder set, one triangle per cycle while the receiver keeps up;
//   after the last triangle the sequencer goes back to idle.
// request.ready is high only while the sequencer is idle; the next request may be
//   taken while the last triangle still sits in the output register.
// A stalled receiver holds the output register and freezes the sequencer; no
//   triangle is dropped or repeated.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
`include "assert_macros.svh"

module triangle_index_generator import tig_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tig_req_if.sink   request,
    tig_tri_if.source triangle
);

    tig_cmd_t    cmd;
    tig_status_t sts;

    tig_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    tig_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (request),
        .triangle (triangle),
        .cmd      (cmd),
        .sts      (sts)
    );

    `TIG_ASSERT_SAME(a_emit_needs_slot, cmd.emit, sts.slot_free)
    `TIG_ASSERT_NEXT(a_last_ends_run, cmd.emit && sts.last, cmd.idle)
    `TIG_ASSERT_SAME(a_mid_run_busy, triangle.valid && !triangle.last, !cmd.idle)

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tig_pkg::*;

    localparam int MAX_PTS     = 32;
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_c;
        logic             last;
    } triangle_t;

    logic clk;
    logic rst_n;

    tig_req_if request_bus ();
    tig_tri_if triangle_bus ();

    triangle_index_generator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus),
        .triangle (triangle_bus)
    );

    triangle_t pending_triangles[$];
    int        src_idle_pct;
    int        sink_stall_pct;
    int        quiet_cycles = 0;
    bit        failed = 1'b0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor

    function automatic void add_triangle(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                                         input logic [IDX_W-1:0] c);
        triangle_t t;
        t.index_a = a;
        t.index_b = b;
        t.index_c = c;
        t.last    = 1'b0;
        pending_triangles.insert(pending_triangles.size(), t);
    endfunction

    function automatic void predict_triangles(input logic op, input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] outer_n,
                                              input logic [CNT_W-1:0] inner_n,
                                              input logic [ALPHA_W-1:0] alpha);
        int               o;
        int               m;
        int               p;
        int               s;
        int               first;
        logic [IDX_W-1:0] ring;
        o = int'(outer_n);
        m = int'(inner_n);
        first = pending_triangles.size();
        if (alpha == '0)
            return;
        if (op == OP_FAN)
        begin
            if (o < 3 || o > MAX_PTS)
                return;
            for (int i = 0; i + 2 < o; i++)
                add_triangle(base, IDX_W'(base + i + 1), IDX_W'(base + i + 2));
        end
        else
        begin
            if (m == 0 || m > o || o > MAX_PTS || o + m < 3)
                return;
            ring = IDX_W'(base + o);
            p = (o - m) / 2;
            s = (o - m) - p;
            for (int i = 0; i < p; i++)
                add_triangle(IDX_W'(base + i), IDX_W'(base + i + 1), ring);
            for (int i = 0; i < s; i++)
                add_triangle(IDX_W'(base + o - i - 2), IDX_W'(base + o - i - 1),
                             IDX_W'(ring + m - 1));
            for (int i = 0; i + 1 < m; i++)
            begin
                add_triangle(IDX_W'(base + p + i), IDX_W'(base + p + i + 1),
                             IDX_W'(ring + i + 1));
                add_triangle(IDX_W'(base + p + i), IDX_W'(ring + i + 1), IDX_W'(ring + i));
            end
        end
        if (pending_triangles.size() > first)
            pending_triangles[pending_triangles.size() - 1].last = 1'b1;
    endfunction

    // Request side

    task automatic send_draw_request(input logic op, input logic [IDX_W-1:0] base,
                                     input logic [CNT_W-1:0] outer_n,
                                     input logic [CNT_W-1:0] inner_n,
                                     input logic [ALPHA_W-1:0] alpha);
        while ($urandom_range(99) < src_idle_pct)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid        <= 1'b1;
        request_bus.opcode       <= op;
        request_bus.base_vertex  <= base;
        request_bus.outer_points <= outer_n;
        request_bus.inner_points <= inner_n;
        request_bus.alpha        <= alpha;
        @(posedge clk);
        while (!request_bus.ready)
            @(posedge clk);
        predict_triangles(op, base, outer_n, inner_n, alpha);
    endtask

    function automatic logic [IDX_W-1:0] random_base();
        // bias toward the top of the index range so wrap-around shows up often
        if ($urandom_range(3) == 0)
            return IDX_W'($urandom_range(65535, 65500));
        return IDX_W'($urandom);
    endfunction

    function automatic logic [ALPHA_W-1:0] random_alpha();
        return ALPHA_W'($urandom_range(255, 1));
    endfunction

    // Triangle side: check and drive ready

    always @(posedge clk)
    begin
        triangle_t got;
        triangle_t want;
        if (rst_n && triangle_bus.valid && triangle_bus.ready)
        begin
            got.index_a = triangle_bus.index_a;
            got.index_b = triangle_bus.index_b;
            got.index_c = triangle_bus.index_c;
            got.last    = triangle_bus.last;
            if (pending_triangles.size() == 0)
            begin
                $error("unexpected triangle word: %0d %0d %0d last %0b",
                       got.index_a, got.index_b, got.index_c, got.last);
                failed = 1'b1;
            end
            else
            begin
                want = pending_triangles.pop_front();
                if (got.index_a !== want.index_a)
                begin
                    $error("index_a: expected %0d, got %0d", want.index_a, got.index_a);
                    failed = 1'b1;
                end
                if (got.index_b !== want.index_b)
                begin
                    $error("index_b: expected %0d, got %0d", want.index_b, got.index_b);
                    failed = 1'b1;
                end
                if (got.index_c !== want.index_c)
                begin
                    $error("index_c: expected %0d, got %0d", want.index_c, got.index_c);
                    failed = 1'b1;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    failed = 1'b1;
                end
            end
        end
        triangle_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog

    always @(posedge clk)
    begin
        if ((request_bus.valid && request_bus.ready) ||
            (triangle_bus.valid && triangle_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Tests

    task automatic test_directed_draws();
        send_draw_request(OP_FAN, 16'd100, 6'd3, 6'd0, 8'd255);      // single triangle
        send_draw_request(OP_FAN, 16'd0, 6'd32, 6'd63, 8'd1);        // largest fan
        send_draw_request(OP_FAN, 16'hFFFF, 6'd5, 6'd0, 8'd128);     // wrap
        send_draw_request(OP_FAN, 16'd7, 6'd2, 6'd0, 8'd9);          // too few points
        send_draw_request(OP_FAN, 16'd7, 6'd0, 6'd0, 8'd9);
        send_draw_request(OP_FAN, 16'd7, 6'd33, 6'd0, 8'd9);         // above max, ignored
        send_draw_request(OP_FAN, 16'd7, 6'd63, 6'd63, 8'd255);
        send_draw_request(OP_FAN, 16'd40, 6'd10, 6'd0, 8'd0);        // alpha zero
        send_draw_request(OP_ARC, 16'd0, 6'd32, 6'd32, 8'd255);      // 62 triangles
        send_draw_request(OP_ARC, 16'd500, 6'd32, 6'd1, 8'd3);
        send_draw_request(OP_ARC, 16'd20, 6'd1, 6'd1, 8'd3);         // too few in total
        send_draw_request(OP_ARC, 16'd20, 6'd2, 6'd1, 8'd3);
        send_draw_request(OP_ARC, 16'd20, 6'd2, 6'd2, 8'd3);
        send_draw_request(OP_ARC, 16'd20, 6'd5, 6'd0, 8'd3);         // no inner ring
        send_draw_request(OP_ARC, 16'd20, 6'd3, 6'd4, 8'd3);         // inner above outer
        send_draw_request(OP_ARC, 16'd20, 6'd40, 6'd10, 8'd3);
        send_draw_request(OP_ARC, 16'hFFFF, 6'd63, 6'd63, 8'd255);
        send_draw_request(OP_ARC, 16'd65530, 6'd10, 6'd4, 8'd77);    // wrap
        send_draw_request(OP_ARC, 16'd300, 6'd12, 6'd6, 8'd0);       // alpha zero
        send_draw_request(OP_ARC, 16'd1000, 6'd7, 6'd3, 8'd200);     // even surplus
        send_draw_request(OP_ARC, 16'd1000, 6'd8, 6'd4, 8'd200);
        send_draw_request(OP_FAN, 16'd65534, 6'd32, 6'd32, 8'd255);
    endtask

    task automatic test_fan_draws(input int count);
        for (int n = 0; n < count; n++)
            send_draw_request(OP_FAN, random_base(), CNT_W'($urandom_range(32, 3)),
                              CNT_W'($urandom), random_alpha());
    endtask

    task automatic test_arc_draws(input int count);
        int o;
        int m;
        for (int n = 0; n < count; n++)
        begin
            o = $urandom_range(32, 2);
            m = $urandom_range(o, 1);
            send_draw_request(OP_ARC, random_base(), CNT_W'(o), CNT_W'(m), random_alpha());
        end
    endtask

    task automatic test_rejected_draws(input int count);
        int  o;
        logic op;
        for (int n = 0; n < count; n++)
        begin
            op = logic'($urandom_range(1));
            case ($urandom_range(5))
                0:
                begin
                    o = $urandom_range(32, 3);
                    send_draw_request(op, random_base(), CNT_W'(o),
                                      CNT_W'($urandom_range(o, 1)), '0);
                end
                1: send_draw_request(OP_FAN, random_base(), CNT_W'($urandom_range(2)),
                                     CNT_W'($urandom), random_alpha());
                2: send_draw_request(op, random_base(), CNT_W'($urandom_range(63, 33)),
                                     CNT_W'($urandom), random_alpha());
                3: send_draw_request(OP_ARC, random_base(), CNT_W'($urandom_range(63)),
                                     '0, random_alpha());
                4:
                begin
                    o = $urandom_range(31);
                    send_draw_request(OP_ARC, random_base(), CNT_W'(o),
                                      CNT_W'($urandom_range(63, o + 1)), random_alpha());
                end
                default: send_draw_request(OP_ARC, random_base(), 6'd1, 6'd1,
                                           random_alpha());
            endcase
        end
    endtask

    task automatic run_random_mix();
        test_fan_draws(60);
        test_arc_draws(70);
        test_rejected_draws(20);
    endtask

    initial
    begin
        src_idle_pct   = 8;
        sink_stall_pct = 59;
        rst_n                    <= 1'b0;
        request_bus.valid        <= 1'b0;
        request_bus.opcode       <= OP_FAN;
        request_bus.base_vertex  <= '0;
        request_bus.outer_points <= '0;
        request_bus.inner_points <= '0;
        request_bus.alpha        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_draws();
        run_random_mix();

        src_idle_pct   = 59;
        sink_stall_pct = 8;
        run_random_mix();

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_mix();

        request_bus.valid <= 1'b0;
        while (pending_triangles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
